### rtl/core/display_keyscan_serial_master_top_macros.svh
// assertion helpers shared by the core
`ifndef DISPLAY_KEYSCAN_SERIAL_MASTER_TOP_MACROS_SVH
`define DISPLAY_KEYSCAN_SERIAL_MASTER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DKSM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holds on every cycle out of reset
`define DKSM_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

`endif

### rtl/core/dksm_pkg.sv
package dksm_pkg;

   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_CMD    = 3'd1;
   localparam logic [2:0] KIND_WRITE  = 3'd2;
   localparam logic [2:0] KIND_READ   = 3'd3;
   localparam logic [2:0] KIND_BRIGHT = 3'd4;

   localparam logic [1:0] TXN_SINGLE = 2'd0;
   localparam logic [1:0] TXN_WRITE  = 2'd1;
   localparam logic [1:0] TXN_READ   = 2'd2;

   localparam logic [7:0] CMD_WRITE_DATA  = 8'h44;
   localparam logic [3:0] CMD_ADDR_HIGH   = 4'hC;
   localparam logic [7:0] CMD_READ_KEYS   = 8'h42;
   localparam logic [7:0] CMD_BRIGHT_BASE = 8'h88;
   localparam logic [3:0] LEVEL_MAX       = 4'd7;

   localparam logic [2:0] KEY_BYTES = 3'd4;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] cmd_byte;
      logic [3:0] reg_address;
      logic [7:0] data_byte;
      logic [3:0] level;
      logic       dio_in;
   } req_type;

   typedef struct packed {
      logic        stb_level;
      logic        clk_level;
      logic        dio_out;
      logic        dio_drive;
      logic        busy_res;
      logic        rejected;
      logic [31:0] key_bits;
      logic        keys_valid;
   } rsp_type;

   typedef struct packed {
      logic       is_request;
      logic [1:0] txn;
      logic [7:0] first_byte;
      logic [3:0] reg_address;
      logic [7:0] data_byte;
      logic       dio_in;
   } op_type;

endpackage

### rtl/core/display_keyscan_serial_master_top.sv
// channel | ports                          | payload
// request | req_valid, req_ready, req_data | dksm_pkg::req_type
// result  | rsp_valid, rsp_ready, rsp_data | dksm_pkg::rsp_type
//
// one request per clock sustained while results are taken; each request yields one result
// an accepted request is written into the queue, and its result is then registered in the pin sequencer
// a two-entry queue between decode and pin sequencer absorbs result stalls
// reset is synchronous: strobe high, clock low, data driven, idle
module display_keyscan_serial_master_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dksm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dksm_pkg::rsp_type rsp_data
);

   dksm_pkg::op_type dec_op;
   dksm_pkg::op_type q_op;
   logic             q_valid;
   logic             q_ready;

   dksm_front u_front (
      .req_data (req_data),
      .op       (dec_op)
   );

   dksm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_op    (dec_op),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_op     (q_op)
   );

   dksm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (q_valid),
      .op_ready  (q_ready),
      .op        (q_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/core/dksm_front.sv
module dksm_front (
   input  dksm_pkg::req_type req_data,
   output dksm_pkg::op_type  op
);

   logic [3:0] level_sat;

   always_comb begin
      level_sat = (req_data.level > dksm_pkg::LEVEL_MAX) ? dksm_pkg::LEVEL_MAX
                                                          : req_data.level;
      op.is_request  = 1'b1;
      op.txn         = dksm_pkg::TXN_SINGLE;
      op.first_byte  = req_data.cmd_byte;
      op.reg_address = req_data.reg_address;
      op.data_byte   = req_data.data_byte;
      op.dio_in      = req_data.dio_in;
      case (req_data.kind)
         dksm_pkg::KIND_CMD: begin
            op.txn        = dksm_pkg::TXN_SINGLE;
            op.first_byte = req_data.cmd_byte;
         end
         dksm_pkg::KIND_WRITE: begin
            op.txn        = dksm_pkg::TXN_WRITE;
            op.first_byte = dksm_pkg::CMD_WRITE_DATA;
         end
         dksm_pkg::KIND_READ: begin
            op.txn        = dksm_pkg::TXN_READ;
            op.first_byte = dksm_pkg::CMD_READ_KEYS;
         end
         dksm_pkg::KIND_BRIGHT: begin
            op.txn        = dksm_pkg::TXN_SINGLE;
            op.first_byte = dksm_pkg::CMD_BRIGHT_BASE | {4'd0, level_sat};
         end
         default: begin
            // tick, and unused kinds act as ticks
            op.is_request = 1'b0;
         end
      endcase
   end

endmodule

### rtl/core/dksm_queue.sv
`include "display_keyscan_serial_master_top_macros.svh"

module dksm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  dksm_pkg::op_type push_op,
   output logic             pop_valid,
   input  logic             pop_ready,
   output dksm_pkg::op_type pop_op
);

   dksm_pkg::op_type entry_ff [dksm_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'(dksm_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   `DKSM_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff != 2'd3, "queue count overflow")
   `DKSM_ASSERT_IMPLIES(a_ptr_match, clock, reset, count_ff == 2'd0 || count_ff == 2'd2, wr_ptr_ff == rd_ptr_ff, "queue pointers out of step")

endmodule

### rtl/core/dksm_back.sv
`include "display_keyscan_serial_master_top_macros.svh"

module dksm_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   output logic              op_ready,
   input  dksm_pkg::op_type  op,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dksm_pkg::rsp_type rsp_data
);

   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_SGL_H = 4'd1;
   localparam logic [3:0] PH_SGL_L = 4'd2;
   localparam logic [3:0] PH_WR_H  = 4'd3;
   localparam logic [3:0] PH_WR_L  = 4'd4;
   localparam logic [3:0] PH_GAP   = 4'd5;
   localparam logic [3:0] PH_RC_H  = 4'd6;
   localparam logic [3:0] PH_RC_L  = 4'd7;
   localparam logic [3:0] PH_RX_H  = 4'd8;
   localparam logic [3:0] PH_RX_L  = 4'd9;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  bit_ff, bit_in;
   logic [1:0]  byte_ff, byte_in;
   logic [31:0] acc_ff, acc_in;
   logic [3:0]  addr_ff, addr_in;
   logic [7:0]  hdata_ff, hdata_in;
   logic        strobe_ff, strobe_in;
   logic        clock_ff, clock_in;
   logic        data_ff, data_in;
   logic        drive_ff, drive_in;
   logic [31:0] keys_ff, keys_in;
   logic        rsp_valid_ff;
   dksm_pkg::rsp_type rsp_ff;
   dksm_pkg::rsp_type rsp_in;
   logic        take;
   logic        rej;
   logic        fin;
   logic [7:0]  gap_byte;

   assign op_ready  = !rsp_valid_ff || rsp_ready;
   assign take      = op_valid && op_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign gap_byte  = {dksm_pkg::CMD_ADDR_HIGH, addr_ff};

   always_comb begin
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      acc_in    = acc_ff;
      addr_in   = addr_ff;
      hdata_in  = hdata_ff;
      strobe_in = strobe_ff;
      clock_in  = clock_ff;
      data_in   = data_ff;
      drive_in  = drive_ff;
      keys_in   = keys_ff;
      rej       = 1'b0;
      fin       = 1'b0;
      if (op.is_request && phase_ff != PH_IDLE) begin
         rej = 1'b1;
      end else if (op.is_request) begin
         strobe_in = 1'b0;
         drive_in  = 1'b1;
         byte_in   = 2'd0;
         shift_in  = op.first_byte;
         bit_in    = 3'd0;
         data_in   = op.first_byte[0];
         clock_in  = 1'b0;
         case (op.txn)
            dksm_pkg::TXN_WRITE: begin
               addr_in  = op.reg_address;
               hdata_in = op.data_byte;
               phase_in = PH_WR_H;
            end
            dksm_pkg::TXN_READ: phase_in = PH_RC_H;
            default:            phase_in = PH_SGL_H;
         endcase
      end else begin
         case (phase_ff)
            PH_SGL_H, PH_WR_H, PH_RC_H: begin
               clock_in = 1'b1;
               phase_in = phase_ff + 4'd1;
            end
            PH_SGL_L, PH_WR_L, PH_RC_L: begin
               clock_in = 1'b0;
               if (bit_ff != 3'd7) begin
                  bit_in   = bit_ff + 3'd1;
                  shift_in = {1'b0, shift_ff[7:1]};
                  data_in  = shift_ff[1];
                  phase_in = phase_ff - 4'd1;
               end else if (phase_ff == PH_SGL_L) begin
                  strobe_in = 1'b1;
                  phase_in  = PH_IDLE;
               end else if (phase_ff == PH_WR_L) begin
                  if (byte_ff == 2'd0) begin
                     strobe_in = 1'b1;
                     phase_in  = PH_GAP;
                  end else if (byte_ff == 2'd1) begin
                     byte_in  = 2'd2;
                     shift_in = hdata_ff;
                     bit_in   = 3'd0;
                     data_in  = hdata_ff[0];
                     phase_in = PH_WR_H;
                  end else begin
                     strobe_in = 1'b1;
                     phase_in  = PH_IDLE;
                  end
               end else begin
                  drive_in = 1'b0;
                  bit_in   = 3'd0;
                  byte_in  = 2'd0;
                  acc_in   = 32'd0;
                  phase_in = PH_RX_H;
               end
            end
            PH_GAP: begin
               strobe_in = 1'b0;
               byte_in   = 2'd1;
               shift_in  = gap_byte;
               bit_in    = 3'd0;
               data_in   = gap_byte[0];
               clock_in  = 1'b0;
               phase_in  = PH_WR_H;
            end
            PH_RX_H: begin
               clock_in = 1'b1;
               acc_in   = acc_ff | (32'(op.dio_in) << {byte_ff, bit_ff});
               phase_in = PH_RX_L;
            end
            PH_RX_L: begin
               clock_in = 1'b0;
               if (bit_ff != 3'd7) begin
                  bit_in   = bit_ff + 3'd1;
                  phase_in = PH_RX_H;
               end else if ({1'b0, byte_ff} + 3'd1 < dksm_pkg::KEY_BYTES) begin
                  byte_in  = byte_ff + 2'd1;
                  bit_in   = 3'd0;
                  phase_in = PH_RX_H;
               end else begin
                  drive_in  = 1'b1;
                  strobe_in = 1'b1;
                  keys_in   = acc_ff;
                  fin       = 1'b1;
                  phase_in  = PH_IDLE;
               end
            end
            PH_IDLE: phase_in = PH_IDLE;
            default: phase_in = PH_IDLE;
         endcase
      end
      rsp_in.stb_level  = strobe_in;
      rsp_in.clk_level  = clock_in;
      rsp_in.dio_out    = data_in;
      rsp_in.dio_drive  = drive_in;
      rsp_in.busy_res   = (phase_in != PH_IDLE);
      rsp_in.rejected   = rej;
      rsp_in.key_bits   = keys_in;
      rsp_in.keys_valid = fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         shift_ff     <= 8'd0;
         bit_ff       <= 3'd0;
         byte_ff      <= 2'd0;
         acc_ff       <= 32'd0;
         addr_ff      <= 4'd0;
         hdata_ff     <= 8'd0;
         strobe_ff    <= 1'b1;
         clock_ff     <= 1'b0;
         data_ff      <= 1'b0;
         drive_ff     <= 1'b1;
         keys_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff  <= phase_in;
            shift_ff  <= shift_in;
            bit_ff    <= bit_in;
            byte_ff   <= byte_in;
            acc_ff    <= acc_in;
            addr_ff   <= addr_in;
            hdata_ff  <= hdata_in;
            strobe_ff <= strobe_in;
            clock_ff  <= clock_in;
            data_ff   <= data_in;
            drive_ff  <= drive_in;
            keys_ff   <= keys_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   `DKSM_ASSERT_IMPLIES(a_idle_pins, clock, reset, phase_ff == PH_IDLE, strobe_ff && !clock_ff, "idle with frame pins active")
   `DKSM_ASSERT_IMPLIES(a_release_rx, clock, reset, !drive_ff, phase_ff == PH_RX_H || phase_ff == PH_RX_L, "data released outside key read")
   `DKSM_ASSERT_IMPLIES(a_keys_done, clock, reset, rsp_valid_ff && rsp_ff.keys_valid, !rsp_ff.busy_res && rsp_ff.dio_drive, "key result while busy")

endmodule
